### rtl/core/ehu_pkg.sv
// Shared types, constants and saturating helpers of the Horn essential matrix decomposition unit.
`timescale 1ns / 1ps
package ehu_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned FracBitsDef = 24;

  typedef logic signed [DataWidth-1:0] word_t;

  localparam word_t MaxW = {1'b0, {(DataWidth-1){1'b1}}};
  localparam word_t MinW = {1'b1, {(DataWidth-1){1'b0}}};

  typedef struct packed {
    word_t e_r0c0;
    word_t e_r0c1;
    word_t e_r0c2;
    word_t e_r1c0;
    word_t e_r1c1;
    word_t e_r1c2;
    word_t e_r2c0;
    word_t e_r2c1;
    word_t e_r2c2;
  } in_item_t;

  typedef struct packed {
    logic       solution;
    logic [1:0] row_index;
    word_t      rot_col0;
    word_t      rot_col1;
    word_t      rot_col2;
    word_t      trans_comp;
    logic       degenerate;
    logic       last_row;
  } res_item_t;

  // One classified matrix on its way to the back end.
  typedef struct packed {
    logic [8:0][DataWidth-1:0] e;
    logic [8:0][DataWidth-1:0] cof;
    logic [2:0][DataWidth-1:0] b;
    logic                      bad;
  } sol_entry_t;

  function automatic word_t sat_w(input logic signed [DataWidth:0] s);
    if (s[DataWidth] != s[DataWidth-1]) begin
      return s[DataWidth] ? MinW : MaxW;
    end
    return s[DataWidth-1:0];
  endfunction

  function automatic word_t addsat(input word_t a, input word_t b);
    return sat_w($signed({a[DataWidth-1], a}) + $signed({b[DataWidth-1], b}));
  endfunction

  function automatic word_t subsat(input word_t a, input word_t b);
    return sat_w($signed({a[DataWidth-1], a}) - $signed({b[DataWidth-1], b}));
  endfunction

  function automatic word_t negsat(input word_t x);
    return (x == MinW) ? MaxW : -x;
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  // Flat index of row r, column c in a row-major 3x3 array.
  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
  endfunction

endpackage

### rtl/core/essential_matrix_decompose_horn_unit.sv
// Front end forms E*E^T, cofactors and the baseline (Q8.24 at defaults) and queues the result;
// the back end builds both rotations with its single bit-serial divider, run once per rotation
// element and skipped when degenerate; a two-entry queue lets the front end take the next matrix
// while the back end works. Rows are never stalled.
// Reset: asynchronous, clears all sequencers and the queue; no data storage is cleared.
`timescale 1ns / 1ps
module essential_matrix_decompose_horn_unit #(
  parameter int unsigned FracBits = ehu_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ehu_pkg::in_item_t  item_i,
  output logic               result_valid_o,
  output ehu_pkg::res_item_t result_o
);
  logic push, full, pop, q_valid;
  ehu_pkg::sol_entry_t f_entry, b_entry;

  ehu_front #(.FracBits(FracBits)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .item_i  (item_i),
    .busy_o  (busy),
    .push_o  (push),
    .entry_o (f_entry),
    .full_i  (full)
  );

  ehu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (b_entry)
  );

  ehu_back #(.FracBits(FracBits)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (b_entry),
    .pop_o       (pop),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule

### rtl/core/ehu_mulq.sv
// Fixed-point multiply with truncation toward zero and saturation.
`timescale 1ns / 1ps
module ehu_mulq #(
  parameter int unsigned FracBits = ehu_pkg::FracBitsDef
) (
  input  ehu_pkg::word_t a_i,
  input  ehu_pkg::word_t b_i,
  output ehu_pkg::word_t p_o
);
  localparam int unsigned W = ehu_pkg::DataWidth;
  localparam logic [2*W-1:0] LimPos = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [2*W-1:0] LimNeg = LimPos + 1'b1;

  logic signed [2*W-1:0] prod;
  logic [2*W-1:0] pmag;
  logic [2*W-1:0] qmag;
  logic [2*W-1:0] lim;
  logic [W-1:0] vmag;
  logic neg;

  assign prod = a_i * b_i;
  assign neg  = prod[2*W-1];
  assign pmag = neg ? -prod : prod;
  assign qmag = pmag >> FracBits;
  assign lim  = neg ? LimNeg : LimPos;
  assign vmag = (qmag > lim) ? lim[W-1:0] : qmag[W-1:0];
  assign p_o  = neg ? -$signed(vmag) : $signed(vmag);

endmodule

### rtl/core/ehu_div.sv
// Bit-serial restoring divider computing (num << FracBits) / den with saturation.
`timescale 1ns / 1ps
module ehu_div #(
  parameter int unsigned FracBits = ehu_pkg::FracBitsDef,
  parameter int unsigned DenW     = ehu_pkg::DataWidth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ehu_pkg::word_t num_i,
  input  logic [DenW-1:0] den_i,
  input  logic           den_neg_i,
  output logic           done_o,
  output ehu_pkg::word_t q_o
);
  localparam int unsigned W    = ehu_pkg::DataWidth;
  localparam int unsigned NB   = W + FracBits;
  localparam int unsigned CntW = $clog2(NB);
  localparam logic [NB-1:0] LimPos = {{(NB-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NB-1:0] LimNeg = LimPos + 1'b1;

  logic busy_q, done_q, neg_q, zero_q;
  logic [CntW-1:0] cnt_q;
  logic [NB-1:0] n_q, quo_q;
  logic [DenW:0] rem_q;
  logic [DenW-1:0] den_q;
  ehu_pkg::word_t q_q;

  logic [W-1:0] num_mag;
  logic [DenW:0] r2, r_next;
  logic bit_c, last;
  logic [NB-1:0] quo_next, lim;
  logic [W-1:0] sat_mag;
  ehu_pkg::word_t q_final;

  assign num_mag  = num_i[W-1] ? W'(-num_i) : W'(num_i);
  assign r2       = {rem_q[DenW-1:0], n_q[NB-1]};
  assign bit_c    = r2 >= {1'b0, den_q};
  assign r_next   = bit_c ? r2 - {1'b0, den_q} : r2;
  assign quo_next = {quo_q[NB-2:0], bit_c};
  assign lim      = neg_q ? LimNeg : LimPos;
  assign sat_mag  = (quo_next > lim) ? lim[W-1:0] : quo_next[W-1:0];
  assign q_final  = zero_q ? '0 : (neg_q ? -$signed(sat_mag) : $signed(sat_mag));
  assign last     = busy_q && (cnt_q == CntW'(NB - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      n_q    <= {num_mag, {FracBits{1'b0}}};
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= den_i;
      neg_q  <= num_i[W-1] ^ den_neg_i;
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      n_q   <= {n_q[NB-2:0], 1'b0};
      rem_q <= r_next;
      quo_q <= quo_next;
      if (last) begin
        q_q <= q_final;
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

### rtl/core/ehu_front.sv
// Front end: takes a matrix, forms E*E^T, cofactors, the baseline and pushes it to the queue.
`timescale 1ns / 1ps
module ehu_front #(
  parameter int unsigned FracBits = ehu_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ehu_pkg::in_item_t   item_i,
  output logic                busy_o,
  output logic                push_o,
  output ehu_pkg::sol_entry_t entry_o,
  input  logic                full_i
);
  localparam int unsigned W      = ehu_pkg::DataWidth;
  localparam int unsigned RadN   = W - 1 + FracBits;
  localparam int unsigned RootW  = (RadN + 1) / 2;
  localparam int unsigned RadW   = 2 * RootW;
  localparam int unsigned SqCntW = $clog2(RootW);

  typedef enum logic [6:0] {
    FIdle = 7'b0000001,
    FEet  = 7'b0000010,
    FCof  = 7'b0000100,
    FSel  = 7'b0001000,
    FSqrt = 7'b0010000,
    FDiv  = 7'b0100000,
    FPush = 7'b1000000
  } fstate_e;

  fstate_e state_q, state_d;
  logic [1:0] i_q, j_q, k_q;
  logic ph_q, div_run_q;
  logic [SqCntW-1:0] sq_cnt_q;

  ehu_pkg::word_t e_q [9];
  ehu_pkg::word_t eet_q [9];
  ehu_pkg::word_t cof_q [9];
  ehu_pkg::word_t brow_q [3];
  ehu_pkg::word_t b_q [3];
  ehu_pkg::word_t acc_q, t_q;
  logic bad_q;
  logic [RadW-1:0] rad_q;
  logic [RootW:0] rem_q;
  logic [RootW-1:0] root_q;

  ehu_pkg::word_t op_a, op_b, mul, acc_d;
  logic [1:0] uc, vc, cp, cq;
  logic last_eet, last_cof, last_sq, div_start, div_done;
  ehu_pkg::word_t div_q;

  ehu_pkg::word_t tr, half, diag0, diag1, diag2, brow_d [3];
  logic [1:0] ksel;
  logic bad_d;

  logic [RootW+2:0] sq_t, sq_trial;
  logic sq_ge;

  always_comb begin
    uc = ehu_pkg::inc3(j_q);
    vc = ehu_pkg::inc3(uc);
    cp = ehu_pkg::inc3(i_q);
    cq = ehu_pkg::inc3(cp);
    op_a = e_q[ehu_pkg::idx3(i_q, k_q)];
    op_b = e_q[ehu_pkg::idx3(j_q, k_q)];
    if (state_q == FCof) begin
      if (!ph_q) begin
        op_a = e_q[ehu_pkg::idx3(cp, uc)];
        op_b = e_q[ehu_pkg::idx3(cq, vc)];
      end else begin
        op_a = e_q[ehu_pkg::idx3(cq, uc)];
        op_b = e_q[ehu_pkg::idx3(cp, vc)];
      end
    end
  end

  ehu_mulq #(.FracBits(FracBits)) u_mul (.a_i(op_a), .b_i(op_b), .p_o(mul));

  assign acc_d    = ehu_pkg::addsat((k_q == 2'd0) ? '0 : acc_q, mul);
  assign last_eet = (i_q == 2'd2) && (j_q == 2'd2) && (k_q == 2'd2);
  assign last_cof = ph_q && (i_q == 2'd2) && (j_q == 2'd2);
  assign last_sq  = (sq_cnt_q == SqCntW'(RootW - 1));

  // Trace is a sum of squares, so halving rounds toward zero as a shift.
  always_comb begin
    tr    = ehu_pkg::addsat(ehu_pkg::addsat(eet_q[0], eet_q[4]), eet_q[8]);
    half  = (tr >>> 1) + ehu_pkg::word_t'({{(W-1){1'b0}}, tr[W-1] & tr[0]});
    diag0 = ehu_pkg::subsat(half, eet_q[0]);
    diag1 = ehu_pkg::subsat(half, eet_q[4]);
    diag2 = ehu_pkg::subsat(half, eet_q[8]);
    priority if (diag0 > diag1 && diag0 > diag2) begin
      ksel = 2'd0;
    end else if (diag1 > diag0 && diag1 > diag2) begin
      ksel = 2'd1;
    end else begin
      ksel = 2'd2;
    end
    for (int c = 0; c < 3; c++) begin
      brow_d[c] = ehu_pkg::subsat((ksel == 2'(c)) ? half : '0,
                                  eet_q[ehu_pkg::idx3(ksel, 2'(c))]);
    end
    bad_d = brow_d[ksel] <= 0;
  end

  assign sq_t     = {rem_q, rad_q[RadW-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  assign div_start = (state_q == FDiv) && !div_run_q;

  ehu_div #(.FracBits(FracBits), .DenW(RootW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .num_i     (brow_q[j_q]),
    .den_i     (root_q),
    .den_neg_i (1'b0),
    .done_o    (div_done),
    .q_o       (div_q)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FIdle: if (start_i) state_d = FEet;
      FEet:  if (last_eet) state_d = FCof;
      FCof:  if (last_cof) state_d = FSel;
      FSel:  state_d = bad_d ? FPush : FSqrt;
      FSqrt: if (last_sq) state_d = FDiv;
      FDiv:  if (div_done && j_q == 2'd2) state_d = FPush;
      FPush: if (!full_i) state_d = FIdle;
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FIdle;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      ph_q      <= 1'b0;
      div_run_q <= 1'b0;
      sq_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        FIdle: begin
          i_q  <= '0;
          j_q  <= '0;
          k_q  <= '0;
          ph_q <= 1'b0;
        end
        FEet: begin
          k_q <= ehu_pkg::inc3(k_q);
          if (k_q == 2'd2) begin
            j_q <= ehu_pkg::inc3(j_q);
            if (j_q == 2'd2) i_q <= ehu_pkg::inc3(i_q);
          end
        end
        FCof: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            i_q <= ehu_pkg::inc3(i_q);
            if (i_q == 2'd2) j_q <= ehu_pkg::inc3(j_q);
          end
        end
        FSel: begin
          j_q      <= '0;
          sq_cnt_q <= '0;
        end
        FSqrt: sq_cnt_q <= sq_cnt_q + 1'b1;
        FDiv: begin
          if (div_start) begin
            div_run_q <= 1'b1;
          end else if (div_done) begin
            div_run_q <= 1'b0;
            j_q       <= ehu_pkg::inc3(j_q);
          end
        end
        FPush: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      FIdle: begin
        if (start_i) begin
          e_q[0] <= item_i.e_r0c0;
          e_q[1] <= item_i.e_r0c1;
          e_q[2] <= item_i.e_r0c2;
          e_q[3] <= item_i.e_r1c0;
          e_q[4] <= item_i.e_r1c1;
          e_q[5] <= item_i.e_r1c2;
          e_q[6] <= item_i.e_r2c0;
          e_q[7] <= item_i.e_r2c1;
          e_q[8] <= item_i.e_r2c2;
        end
      end
      FEet: begin
        acc_q <= acc_d;
        if (k_q == 2'd2) eet_q[ehu_pkg::idx3(i_q, j_q)] <= acc_d;
      end
      FCof: begin
        if (!ph_q) t_q <= mul;
        else cof_q[ehu_pkg::idx3(j_q, i_q)] <= ehu_pkg::subsat(t_q, mul);
      end
      FSel: begin
        for (int c = 0; c < 3; c++) begin
          brow_q[c] <= brow_d[c];
          b_q[c]    <= '0;
        end
        bad_q  <= bad_d;
        rad_q  <= RadW'({brow_d[ksel][W-2:0], {FracBits{1'b0}}});
        rem_q  <= '0;
        root_q <= '0;
      end
      FSqrt: begin
        rad_q <= {rad_q[RadW-3:0], 2'b00};
        if (sq_ge) begin
          rem_q  <= (RootW+1)'(sq_t - sq_trial);
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= sq_t[RootW:0];
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      FDiv: if (div_done) b_q[j_q] <= div_q;
      FPush: ;
      default: ;
    endcase
  end

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      entry_o.e[n]   = e_q[n];
      entry_o.cof[n] = cof_q[n];
    end
    for (int c = 0; c < 3; c++) begin
      entry_o.b[c] = b_q[c];
    end
    entry_o.bad = bad_q;
  end

  assign busy_o = (state_q != FIdle);
  assign push_o = (state_q == FPush) && !full_i;

endmodule

### rtl/core/ehu_fifo.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module ehu_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ehu_pkg::sol_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output ehu_pkg::sol_entry_t entry_o
);
  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  ehu_pkg::sol_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

endmodule

### rtl/core/ehu_back.sv
// Back end: builds both rotations from a queued item, unless it is degenerate, and emits six result rows.
`timescale 1ns / 1ps
module ehu_back #(
  parameter int unsigned FracBits = ehu_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ehu_pkg::sol_entry_t entry_i,
  output logic                pop_o,
  output logic                res_valid_o,
  output ehu_pkg::res_item_t  res_o
);
  localparam int unsigned W = ehu_pkg::DataWidth;

  typedef enum logic [5:0] {
    BIdle = 6'b000001,
    BBb   = 6'b000010,
    BM1   = 6'b000100,
    BM2   = 6'b001000,
    BDiv  = 6'b010000,
    BEmit = 6'b100000
  } bstate_e;

  bstate_e state_q, state_d;
  logic [1:0] i_q, j_q;
  logic s_q, run_q, res_valid_q;
  ehu_pkg::sol_entry_t ent_q;
  ehu_pkg::word_t acc_q, t_q, bb_q, num_q;
  ehu_pkg::word_t rot_q [9];
  logic deg_q;
  ehu_pkg::res_item_t res_q;

  ehu_pkg::word_t bs [3];
  ehu_pkg::word_t op_a, op_b, mul, acc_d, w_d, div_q;
  logic [1:0] cp, cq;
  logic div_start, div_done, last_el, deg_d;
  logic [W-1:0] den_mag;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bs[c] = s_q ? ehu_pkg::negsat($signed(ent_q.b[c])) : $signed(ent_q.b[c]);
    end
    cp = ehu_pkg::inc3(i_q);
    cq = ehu_pkg::inc3(cp);
    op_a = bs[j_q];
    op_b = bs[j_q];
    if (state_q == BM1) begin
      op_a = bs[cp];
      op_b = $signed(ent_q.e[ehu_pkg::idx3(cq, j_q)]);
    end else if (state_q == BM2) begin
      op_a = bs[cq];
      op_b = $signed(ent_q.e[ehu_pkg::idx3(cp, j_q)]);
    end
  end

  ehu_mulq #(.FracBits(FracBits)) u_mul (.a_i(op_a), .b_i(op_b), .p_o(mul));

  assign acc_d   = ehu_pkg::addsat((j_q == 2'd0) ? '0 : acc_q, mul);
  assign deg_d   = ent_q.bad || (acc_d == '0);
  assign w_d     = ehu_pkg::subsat(t_q, mul);
  assign last_el = (i_q == 2'd2) && (j_q == 2'd2);
  assign den_mag = bb_q[W-1] ? W'(-bb_q) : W'(bb_q);

  assign div_start = (state_q == BDiv) && !run_q;

  ehu_div #(.FracBits(FracBits), .DenW(W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .num_i     (num_q),
    .den_i     (den_mag),
    .den_neg_i (bb_q[W-1]),
    .done_o    (div_done),
    .q_o       (div_q)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BIdle: if (valid_i) state_d = BBb;
      BBb:   if (j_q == 2'd2) state_d = deg_d ? BEmit : BM1;
      BM1:   state_d = BM2;
      BM2:   state_d = BDiv;
      BDiv:  if (div_done) state_d = last_el ? BEmit : BM1;
      BEmit: if (i_q == 2'd2) state_d = s_q ? BIdle : BBb;
      default: state_d = BIdle;
    endcase
  end

  assign pop_o = (state_q == BIdle) && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      i_q         <= '0;
      j_q         <= '0;
      s_q         <= 1'b0;
      run_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == BEmit);
      unique case (state_q)
        BIdle: begin
          i_q <= '0;
          j_q <= '0;
          s_q <= 1'b0;
        end
        BBb: j_q <= ehu_pkg::inc3(j_q);
        BM1: ;
        BM2: ;
        BDiv: begin
          if (div_start) begin
            run_q <= 1'b1;
          end else if (div_done) begin
            run_q <= 1'b0;
            i_q   <= ehu_pkg::inc3(i_q);
            if (i_q == 2'd2) j_q <= ehu_pkg::inc3(j_q);
          end
        end
        BEmit: begin
          i_q <= ehu_pkg::inc3(i_q);
          if (i_q == 2'd2) s_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BIdle: if (valid_i) ent_q <= entry_i;
      BBb: begin
        acc_q <= acc_d;
        if (j_q == 2'd2) begin
          bb_q  <= acc_d;
          deg_q <= deg_d;
        end
      end
      BM1: t_q <= mul;
      BM2: num_q <= ehu_pkg::subsat($signed(ent_q.cof[ehu_pkg::idx3(j_q, i_q)]), w_d);
      BDiv: if (div_done) rot_q[ehu_pkg::idx3(i_q, j_q)] <= div_q;
      BEmit: begin
        res_q.solution   <= s_q;
        res_q.row_index  <= i_q;
        res_q.rot_col0   <= deg_q ? '0 : rot_q[ehu_pkg::idx3(i_q, 2'd0)];
        res_q.rot_col1   <= deg_q ? '0 : rot_q[ehu_pkg::idx3(i_q, 2'd1)];
        res_q.rot_col2   <= deg_q ? '0 : rot_q[ehu_pkg::idx3(i_q, 2'd2)];
        res_q.trans_comp <= deg_q ? '0 : bs[i_q];
        res_q.degenerate <= deg_q;
        res_q.last_row   <= s_q && (i_q == 2'd2);
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
